FILE: rtl/swm_pkg.sv
// Shared types and constants of the sliding window median filter.
`default_nettype none

package swm_pkg;

    localparam int DATA_W         = 32;
    localparam int CFG_W          = 7;
    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [CFG_W-1:0] WIN_RESET = 7'd3;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REMOVE = 4'b0010,
        S_INSERT = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    // Commands broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic                     shift;
        logic                     remove;
        logic                     insert;
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] oldest;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/sliding_window_median.sv
// Sliding window median filter: top level with sequencer and cell row.
//
// Usage: samples arrive on the s_axis channel (tdata = 32-bit signed sample),
// lower medians leave on the m_axis channel (tdata = 32-bit signed median).
// The window size is written through the cfg channel (7-bit value, zero acts
// as one, values above MAX_WINDOW act as MAX_WINDOW); a write restarts the
// fill, so no median appears until that many new samples have arrived. A write
// is taken only between samples and goes ahead of a sample offered with it.
// While the window is still filling, a sample takes only an insert step (the
// one that completes it also an emit step); once it is full, it takes a remove
// step and an insert step on the sorted cell row, then an emit step that loads
// the output register. The row is one cell per window slot; every cell updates
// in parallel from its neighbors. A new sample is taken while a median still
// waits in the output register; if the receiver stalls, the next median holds
// in the sequencer and no further sample is accepted until the output register
// frees up. Reset clears the sequencer, the fill count and the output valid and
// sets the window size to 3; sample storage needs no reset.
`default_nettype none

module sliding_window_median #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Config write channel: window_size in bits 6:0.
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [swm_pkg::CFG_W-1:0]          i_cfg_data,
    // Sample stream, tdata: sample [31:0].
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire signed [swm_pkg::DATA_W-1:0]  s_axis_tdata,
    // Median stream, tdata: median [31:0].
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic signed [swm_pkg::DATA_W-1:0] m_axis_tdata
);

    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    function automatic logic [WW-1:0] eff_window(input logic [swm_pkg::CFG_W-1:0] v);
        int unsigned t;
        t = int'(v);
        if (t == 0) begin
            t = 1;
        end
        if (t > MAX_WINDOW) begin
            t = MAX_WINDOW;
        end
        return WW'(t);
    endfunction

    swm_pkg::t_state r_state, n_state;

    logic [WW-1:0]                     r_win;
    logic [WW-1:0]                     r_fill;
    logic                              r_full;
    logic signed [swm_pkg::DATA_W-1:0] r_sample;
    logic signed [swm_pkg::DATA_W-1:0] r_oldest;
    logic                              r_out_valid;
    logic signed [swm_pkg::DATA_W-1:0] r_median;

    logic                              in_beat;
    logic                              cfg_beat;
    logic                              out_load;
    logic [WW-1:0]                     count;
    logic [WW-1:0]                     win_m1;
    logic [WW-1:0]                     mid;
    logic [swm_pkg::DATA_W-1:0]        oldest_tap;
    logic [swm_pkg::DATA_W-1:0]        median_tap;
    swm_pkg::t_cell_ctrl               ctrl;

    logic [MAX_WINDOW-1:0][swm_pkg::DATA_W-1:0] arr;
    logic [MAX_WINDOW-1:0][swm_pkg::DATA_W-1:0] val;
    logic [MAX_WINDOW-1:0]                      gt;

    assign o_cfg_ready   = (r_state == swm_pkg::S_IDLE);
    assign cfg_beat      = i_cfg_valid && o_cfg_ready;
    assign s_axis_tready = (r_state == swm_pkg::S_IDLE) && !i_cfg_valid;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_median;
    assign out_load      = (r_state == swm_pkg::S_EMIT) && (!r_out_valid || m_axis_tready);

    assign win_m1 = r_win - WW'(1);
    assign mid    = win_m1 >> 1;
    // A full window drops one entry before the insert, so it inserts into win-1 entries.
    assign count  = r_full ? win_m1 : r_fill;

    always_comb begin
        ctrl.shift  = in_beat;
        ctrl.remove = (r_state == swm_pkg::S_REMOVE);
        ctrl.insert = (r_state == swm_pkg::S_INSERT);
        ctrl.sample = r_sample;
        ctrl.oldest = r_oldest;
    end

    generate
        for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
            logic signed [swm_pkg::DATA_W-1:0] arr_left;
            logic signed [swm_pkg::DATA_W-1:0] val_left;
            logic signed [swm_pkg::DATA_W-1:0] val_right;
            logic                              gt_left;
            logic signed [swm_pkg::DATA_W-1:0] arr_q;
            logic signed [swm_pkg::DATA_W-1:0] val_q;

            if (j == 0) begin : g_first
                assign arr_left = s_axis_tdata;
                assign val_left = '0;
                assign gt_left  = 1'b0;
            end else begin : g_inner
                assign arr_left = arr[j-1];
                assign val_left = val[j-1];
                assign gt_left  = gt[j-1];
            end

            if (j == MAX_WINDOW - 1) begin : g_last
                assign val_right = val[j];
            end else begin : g_mid
                assign val_right = val[j+1];
            end

            swm_cell #(
                .IDX (j),
                .WW  (WW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_count     (count),
                .i_win       (r_win),
                .i_arr_left  (arr_left),
                .i_val_left  (val_left),
                .i_val_right (val_right),
                .i_gt_left   (gt_left),
                .o_arr       (arr_q),
                .o_val       (val_q),
                .o_gt        (gt[j])
            );

            assign arr[j] = arr_q;
            assign val[j] = val_q;
        end
    endgenerate

    swm_tap_mux #(
        .N  (MAX_WINDOW),
        .IW (IW)
    ) u_oldest_mux (
        .i_data (arr),
        .i_sel  (win_m1[IW-1:0]),
        .o_data (oldest_tap)
    );

    swm_tap_mux #(
        .N  (MAX_WINDOW),
        .IW (IW)
    ) u_median_mux (
        .i_data (val),
        .i_sel  (mid[IW-1:0]),
        .o_data (median_tap)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            swm_pkg::S_IDLE: begin
                if (in_beat) begin
                    n_state = (r_fill == r_win) ? swm_pkg::S_REMOVE : swm_pkg::S_INSERT;
                end
            end
            swm_pkg::S_REMOVE: begin
                n_state = swm_pkg::S_INSERT;
            end
            swm_pkg::S_INSERT: begin
                if (r_full || (r_fill + WW'(1) == r_win)) begin
                    n_state = swm_pkg::S_EMIT;
                end else begin
                    n_state = swm_pkg::S_IDLE;
                end
            end
            swm_pkg::S_EMIT: begin
                if (out_load) begin
                    n_state = swm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swm_pkg::S_IDLE;
            r_win       <= eff_window(swm_pkg::WIN_RESET);
            r_fill      <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_beat) begin
                r_win  <= eff_window(i_cfg_data);
                r_fill <= '0;
            end else if ((r_state == swm_pkg::S_INSERT) && !r_full) begin
                r_fill <= r_fill + WW'(1);
            end
            if (in_beat) begin
                r_full <= (r_fill == r_win);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_sample <= s_axis_tdata;
            r_oldest <= oldest_tap;
        end
        if (out_load) begin
            r_median <= median_tap;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/swm_cell.sv
// One cell of the row: one tap of the arrival line and one slot of the sorted store.
`default_nettype none

module swm_cell #(
    parameter int IDX = 0,
    parameter int WW  = 7
) (
    input  wire                             i_clk,
    input  wire swm_pkg::t_cell_ctrl        i_ctrl,
    input  wire        [WW-1:0]             i_count,
    input  wire        [WW-1:0]             i_win,
    input  wire signed [swm_pkg::DATA_W-1:0] i_arr_left,
    input  wire signed [swm_pkg::DATA_W-1:0] i_val_left,
    input  wire signed [swm_pkg::DATA_W-1:0] i_val_right,
    input  wire                             i_gt_left,
    output logic signed [swm_pkg::DATA_W-1:0] o_arr,
    output logic signed [swm_pkg::DATA_W-1:0] o_val,
    output logic                            o_gt
);

    localparam logic [WW-1:0] MY_IDX = WW'(IDX);
    localparam logic [WW-1:0] MY_NXT = WW'(IDX + 1);

    logic signed [swm_pkg::DATA_W-1:0] r_arr;
    logic signed [swm_pkg::DATA_W-1:0] r_val;
    logic signed [swm_pkg::DATA_W-1:0] n_val;

    // True when this slot holds a valid entry larger than the new sample.
    assign o_gt  = (MY_IDX < i_count) && (r_val > i_ctrl.sample);
    assign o_arr = r_arr;
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.remove && (MY_NXT < i_win)) begin
            // Every slot at or beyond the first copy of the oldest value moves down one.
            if (r_val >= i_ctrl.oldest) begin
                n_val = i_val_right;
            end
        end else if (i_ctrl.insert && (MY_IDX <= i_count)) begin
            if (i_gt_left) begin
                n_val = i_val_left;
            end else if (o_gt || (MY_IDX == i_count)) begin
                n_val = i_ctrl.sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_arr <= i_arr_left;
        end
        r_val <= n_val;
    end

endmodule

`default_nettype wire

FILE: rtl/swm_tap_mux.sv
// Selects one entry of the cell row by index.
`default_nettype none

module swm_tap_mux #(
    parameter int N  = 64,
    parameter int IW = 6
) (
    input  wire [N-1:0][swm_pkg::DATA_W-1:0] i_data,
    input  wire [IW-1:0]                     i_sel,
    output logic [swm_pkg::DATA_W-1:0]       o_data
);

    always_comb begin
        o_data = '0;
        for (int j = 0; j < N; j++) begin
            if (i_sel == IW'(j)) begin
                o_data = o_data | i_data[j];
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_sliding_window_median.sv
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 100ps
`default_nettype none

module tb_sliding_window_median;

    localparam int WIN_DEPTH      = swm_pkg::MAX_WINDOW_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;

    localparam logic signed [swm_pkg::DATA_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [swm_pkg::DATA_W-1:0] S_MAX = 32'sh7fff_ffff;

    // Tracks the window exactly as the filter should and queues the medians it must emit.
    class median_scoreboard;
        logic [swm_pkg::CFG_W-1:0]         win_reg;
        logic signed [swm_pkg::DATA_W-1:0] history [WIN_DEPTH];
        logic signed [swm_pkg::DATA_W-1:0] sorted_win [WIN_DEPTH];
        int unsigned                       filled;
        logic signed [swm_pkg::DATA_W-1:0] pending_medians [$];
        int                                errors;
        int                                samples_seen;
        int                                medians_seen;
        int                                window_writes;

        function new();
            win_reg = swm_pkg::WIN_RESET;
            filled  = 0;
            foreach (history[i]) begin
                history[i]    = '0;
                sorted_win[i] = '0;
            end
            errors        = 0;
            samples_seen  = 0;
            medians_seen  = 0;
            window_writes = 0;
        endfunction

        function void set_window(logic [swm_pkg::CFG_W-1:0] value);
            win_reg = value;
            filled  = 0;
            window_writes++;
        endfunction

        // Zero acts as one and anything past the row depth saturates.
        function int unsigned span();
            int unsigned w;
            w = 32'(win_reg);
            if (w == 0) w = 1;
            if (w > WIN_DEPTH) w = WIN_DEPTH;
            return w;
        endfunction

        function void sorted_put(int unsigned n, logic signed [swm_pkg::DATA_W-1:0] value);
            int unsigned i;
            i = n;
            while (i > 0 && sorted_win[i-1] > value) begin
                sorted_win[i] = sorted_win[i-1];
                i--;
            end
            sorted_win[i] = value;
        endfunction

        function void note_sample(logic signed [swm_pkg::DATA_W-1:0] value);
            int unsigned                       w;
            int unsigned                       pos;
            logic signed [swm_pkg::DATA_W-1:0] oldest;
            w = span();
            samples_seen++;
            if (filled > w) filled = 0;
            if (filled == w) begin
                // Drop one copy of the oldest sample by value, then slot the new one in.
                oldest = history[w-1];
                pos    = w - 1;
                for (int unsigned i = 0; i < w; i++) begin
                    if (sorted_win[i] == oldest) begin
                        pos = i;
                        break;
                    end
                end
                for (int unsigned i = pos; i + 1 < w; i++)
                    sorted_win[i] = sorted_win[i+1];
                sorted_put(w - 1, value);
            end else begin
                sorted_put(filled, value);
                filled++;
            end
            for (int i = WIN_DEPTH - 1; i > 0; i--)
                history[i] = history[i-1];
            history[0] = value;
            if (filled == w)
                pending_medians.push_back(sorted_win[(w-1)/2]);
        endfunction

        function void check_median(logic signed [swm_pkg::DATA_W-1:0] got);
            logic signed [swm_pkg::DATA_W-1:0] want;
            if (pending_medians.size() == 0) begin
                $error("median beat %0d arrived with none expected (median = %0d)",
                       medians_seen, got);
                errors++;
            end else begin
                want = pending_medians.pop_front();
                if (got !== want) begin
                    $error("median mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
            medians_seen++;
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    wire                               o_cfg_ready;
    logic [swm_pkg::CFG_W-1:0]         i_cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    wire                               s_axis_tready;
    logic signed [swm_pkg::DATA_W-1:0] s_axis_tdata = '0;   // sample [31:0]
    wire                               m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    wire signed [swm_pkg::DATA_W-1:0]  m_axis_tdata;        // median [31:0]

    median_scoreboard sb = new();

    int tx_gap_max = 6;
    int rx_stall_max = 6;
    int rx_hold = 0;
    int idle_cycles = 0;
    logic signed [swm_pkg::DATA_W-1:0] last_sample = '0;

    sliding_window_median dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Median sink with random back-pressure; a requested hold is honored after the next beat.
    initial begin : median_sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = (rx_hold > 0) ? rx_hold : $urandom_range(0, rx_stall_max);
            rx_hold = 0;
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_median(m_axis_tdata);
        end
    end

    // Valid stays high between back-to-back beats; it drops only when a gap is drawn or stop_samples ends the stream.
    task automatic push_sample(input logic signed [swm_pkg::DATA_W-1:0] value);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(value);
        last_sample = value;
    endtask

    task automatic stop_samples();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // A sample that fills nothing yields no median, so allow the pipeline to drain after that.
    task automatic wait_quiet();
        while (sb.pending_medians.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [swm_pkg::CFG_W-1:0] value);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_window(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small values so duplicates are common, with full-range values and extremes mixed in.
    function automatic logic signed [swm_pkg::DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $signed($urandom_range(0, 16)) - 8;
            6, 7:             return $urandom;
            8: begin
                case ($urandom_range(0, 3))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            default:          return last_sample;
        endcase
    endfunction

    task automatic run_phase(input int items);
        for (int k = 0; k < items; k++)
            push_sample(pick_sample());
        stop_samples();
    endtask

    initial begin : stimulus
        logic [swm_pkg::CFG_W-1:0] win;
        int                        items;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of three: extremes, equal samples, sign boundaries.
        push_sample(S_MIN);
        push_sample(S_MAX);
        push_sample('0);
        push_sample(-1);
        push_sample(-1);
        push_sample(S_MAX);
        stop_samples();

        // Zero behaves as a window of one.
        write_window(7'd0);
        push_sample(S_MIN);
        push_sample(S_MAX);
        push_sample(1);
        stop_samples();

        // Even window reports the smaller middle value.
        write_window(7'd2);
        push_sample(5);
        push_sample(5);
        push_sample(-5);
        stop_samples();

        // Rewriting the size while partly filled restarts the fill.
        write_window(7'd4);
        push_sample(1);
        push_sample(2);
        stop_samples();
        write_window(7'd4);
        push_sample(7);
        push_sample(S_MIN);
        push_sample(7);
        push_sample(S_MAX);
        stop_samples();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       win = 7'd1;
                1:       win = 7'd64;
                2:       win = 7'd127;
                3:       win = 7'd3;
                4:       win = 7'd65;
                5:       win = 7'd0;
                6:       win = swm_pkg::CFG_W'($urandom_range(2, 12));
                7:       win = swm_pkg::CFG_W'($urandom_range(13, 63));
                default: win = swm_pkg::CFG_W'($urandom_range(0, 127));
            endcase
            items = (win > 32 || win == 0) ? 130 : 90;
            write_window(win);
            tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
            rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            if (p == 3) begin
                // Sink stops for a long stretch while samples keep coming at full rate.
                tx_gap_max = 0;
                rx_hold    = LONG_HOLD;
            end
            run_phase(items / 2);
            // Sender sits out until every median so far has been returned.
            wait_quiet();
            run_phase(items - items / 2);
        end

        while (sb.pending_medians.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples and %0d medians across %0d window size writes,",
                 sb.samples_seen, sb.medians_seen, sb.window_writes);
        $display("including sizes 0, 1, 2, 64, 65 and 127, and a long sink stall.");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_tap_mux.sv
rtl/sliding_window_median.sv
tb/sv/tb_sliding_window_median.sv
